// ===== hw/rtl/bsc_pkg.sv =====
// bsc_pkg: shared types and constants of the bit-serial convolution layer
// used by bsc_ctrl, bsc_datapath and bit_serial_conv_layer; no dependencies
package bsc_pkg;

	// item kinds on the input tuser
	localparam logic [1:0] MODE_NEURON = 2'd0;
	localparam logic [1:0] MODE_WEIGHT = 2'd1;
	localparam logic [1:0] MODE_START  = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_NEURON_BITS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE      = 1'b1;

	// fixed field widths
	localparam int VALUE_W = 16;
	localparam int SUM_W   = 40;
	localparam int OUT_DATA_W = 48;

	// result cap per run
	localparam int MAX_RESULTS = 50;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	// command word from controller to datapath
	typedef struct packed {
		logic       start;
		logic       ld_neuron;
		logic       ld_weight;
		logic       tap;
		logic [3:0] bit_idx;
		logic       emit;
		logic       last;
		logic [2:0] out_x;
		logic [2:0] out_y;
		logic       out_f;
	} bsc_cmd_t;

endpackage

// ===== hw/rtl/bsc_ctrl.sv =====
// bsc_ctrl: controller of the bit-serial convolution layer; holds the
// configuration registers, the loop counters and the run state machine
// depends on bsc_pkg
module bsc_ctrl import bsc_pkg::*; #(
	parameter int IN_X     = 8,
	parameter int IN_Y     = 8,
	parameter int CHANNELS = 3,
	parameter int FILTERS  = 2,
	parameter int WIN_X    = 4,
	parameter int WIN_Y    = 4,
	localparam int IW  = (WIN_X > 1) ? $clog2(WIN_X) : 1,
	localparam int JW  = (WIN_Y > 1) ? $clog2(WIN_Y) : 1,
	localparam int KW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
	localparam int FW  = (FILTERS > 1) ? $clog2(FILTERS) : 1,
	localparam int PXW = $clog2(IN_X + 5),
	localparam int PYW = $clog2(IN_Y + 5)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic [1:0]            in_mode,
	output logic                  in_ready,
	input  logic                  out_free,
	output bsc_cmd_t              cmd,
	output logic [IW-1:0]         tap_i,
	output logic [JW-1:0]         tap_j,
	output logic [KW-1:0]         tap_k,
	output logic [FW-1:0]         tap_f,
	output logic [PXW-1:0]        corner_x,
	output logic [PYW-1:0]        corner_y
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam bit HAS_OUT = (WIN_X <= IN_X) && (WIN_Y <= IN_Y);

	logic [1:0]           state_q;
	logic [4:0]           nbits_q;
	logic [2:0]           stride_q;
	logic [3:0]           b_q;
	logic [IW-1:0]        i_q;
	logic [JW-1:0]        j_q;
	logic [KW-1:0]        k_q;
	logic [FW-1:0]        f_q;
	logic [PXW-1:0]       cx_q, ox_q;
	logic [PYW-1:0]       cy_q, oy_q;
	logic [RES_CNT_W-1:0] n_q;

	logic [4:0] nb_eff;
	logic [2:0] st_eff;
	logic       accept, start_acc;
	logic       last_i, last_j, last_k, last_b, last_f, last_x, last_y, last_out;
	logic       do_emit;

	// effective settings
	assign nb_eff = (nbits_q > 5'd16) ? 5'd16 : nbits_q;
	assign st_eff = (stride_q == 3'd0) ? 3'd1 : stride_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign start_acc = accept && (in_mode == MODE_START);

	// loop ends
	assign last_i = (i_q == IW'(WIN_X - 1));
	assign last_j = (j_q == JW'(WIN_Y - 1));
	assign last_k = (k_q == KW'(CHANNELS - 1));
	assign last_b = ({1'b0, b_q} == nb_eff - 5'd1);
	assign last_f = (f_q == FW'(FILTERS - 1));
	assign last_x = (cx_q + PXW'(st_eff) + PXW'(WIN_X)) > PXW'(IN_X);
	assign last_y = (cy_q + PYW'(st_eff) + PYW'(WIN_Y)) > PYW'(IN_Y);
	assign last_out = (n_q == RES_CNT_W'(MAX_RESULTS - 1)) || (last_x && last_y && last_f);
	assign do_emit  = (state_q == ST_EMIT) && out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nbits_q  <= 5'd4;
			stride_q <= 3'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NEURON_BITS: nbits_q  <= cfg_data;
				CFG_STRIDE:      stride_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// run state machine and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			b_q  <= '0;
			i_q  <= '0;
			j_q  <= '0;
			k_q  <= '0;
			f_q  <= '0;
			cx_q <= '0;
			cy_q <= '0;
			ox_q <= '0;
			oy_q <= '0;
			n_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start_acc && HAS_OUT) begin
						b_q  <= '0;
						i_q  <= '0;
						j_q  <= '0;
						k_q  <= '0;
						f_q  <= '0;
						cx_q <= '0;
						cy_q <= '0;
						ox_q <= '0;
						oy_q <= '0;
						n_q  <= '0;
						state_q <= (nb_eff == 5'd0) ? ST_EMIT : ST_RUN;
					end
				end
				ST_RUN: begin
					// walk i, then j, then k, then bit
					if (!last_i) begin
						i_q <= i_q + 1'b1;
					end else begin
						i_q <= '0;
						if (!last_j) begin
							j_q <= j_q + 1'b1;
						end else begin
							j_q <= '0;
							if (!last_k) begin
								k_q <= k_q + 1'b1;
							end else begin
								k_q <= '0;
								if (!last_b) begin
									b_q <= b_q + 1'b1;
								end else begin
									b_q <= '0;
									state_q <= ST_DRAIN;
								end
							end
						end
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						n_q <= n_q + 1'b1;
						if (last_out) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= (nb_eff == 5'd0) ? ST_EMIT : ST_RUN;
							if (!last_f) begin
								f_q <= f_q + 1'b1;
							end else begin
								f_q <= '0;
								if (!last_y) begin
									cy_q <= cy_q + PYW'(st_eff);
									oy_q <= oy_q + 1'b1;
								end else begin
									cy_q <= '0;
									oy_q <= '0;
									cx_q <= cx_q + PXW'(st_eff);
									ox_q <= ox_q + 1'b1;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// commands to the datapath
	always_comb begin
		cmd           = '0;
		cmd.start     = start_acc;
		cmd.ld_neuron = accept && (in_mode == MODE_NEURON);
		cmd.ld_weight = accept && (in_mode == MODE_WEIGHT);
		cmd.tap       = (state_q == ST_RUN);
		cmd.bit_idx   = b_q;
		cmd.emit      = do_emit;
		cmd.last      = last_out;
		cmd.out_x     = ox_q[2:0];
		cmd.out_y     = oy_q[2:0];
		cmd.out_f     = f_q[0];
	end

	assign tap_i    = i_q;
	assign tap_j    = j_q;
	assign tap_k    = k_q;
	assign tap_f    = f_q;
	assign corner_x = cx_q;
	assign corner_y = cy_q;

	// a result is only pushed into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("emit while output register busy");

	// no input word is taken while taps are issued
	a_tap_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tap |-> !(cmd.ld_neuron || cmd.ld_weight || cmd.start))
		else $error("input accepted during a run");

endmodule

// ===== hw/rtl/bsc_datapath.sv =====
// bsc_datapath: neuron and weight memories, load pointers, bit-serial
// accumulator and output register of the convolution layer
// depends on bsc_pkg
module bsc_datapath import bsc_pkg::*; #(
	parameter int IN_X     = 8,
	parameter int IN_Y     = 8,
	parameter int CHANNELS = 3,
	parameter int FILTERS  = 2,
	parameter int WIN_X    = 4,
	parameter int WIN_Y    = 4,
	localparam int IW  = (WIN_X > 1) ? $clog2(WIN_X) : 1,
	localparam int JW  = (WIN_Y > 1) ? $clog2(WIN_Y) : 1,
	localparam int KW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
	localparam int FW  = (FILTERS > 1) ? $clog2(FILTERS) : 1,
	localparam int PXW = $clog2(IN_X + 5),
	localparam int PYW = $clog2(IN_Y + 5)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bsc_cmd_t              cmd,
	input  logic [IW-1:0]         tap_i,
	input  logic [JW-1:0]         tap_j,
	input  logic [KW-1:0]         tap_k,
	input  logic [FW-1:0]         tap_f,
	input  logic [PXW-1:0]        corner_x,
	input  logic [PYW-1:0]        corner_y,
	input  logic [VALUE_W-1:0]    value,
	output logic                  out_free,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic                  out_last
);

	localparam int N_DEPTH = IN_X * IN_Y * CHANNELS;
	localparam int W_DEPTH = FILTERS * CHANNELS * WIN_Y * WIN_X;
	localparam int NAW = (N_DEPTH > 1) ? $clog2(N_DEPTH) : 1;
	localparam int WAW = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
	localparam int NCW = $clog2(N_DEPTH + 1);
	localparam int WCW = $clog2(W_DEPTH + 1);

	logic [VALUE_W-1:0] nmem [N_DEPTH];
	logic [VALUE_W-1:0] wmem [W_DEPTH];

	logic [NCW-1:0]     nptr_q;
	logic [WCW-1:0]     wptr_q;
	logic [NAW-1:0]     n_row, n_addr;
	logic [WAW-1:0]     w_row, w_addr;
	logic [VALUE_W-1:0] n_rd_s1, w_rd_s1;
	logic [3:0]         b_s1;
	logic               tap_s1;
	logic [SUM_W-1:0]   acc_q, addend;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic               out_last_q;

	// read addresses for the current tap
	assign n_row  = NAW'(tap_k) * NAW'(IN_Y) + NAW'(corner_y) + NAW'(tap_j);
	assign n_addr = n_row * NAW'(IN_X) + NAW'(corner_x) + NAW'(tap_i);
	assign w_row  = (WAW'(tap_f) * WAW'(CHANNELS) + WAW'(tap_k)) * WAW'(WIN_Y) + WAW'(tap_j);
	assign w_addr = w_row * WAW'(WIN_X) + WAW'(tap_i);

	// load pointers, cleared by a start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nptr_q <= '0;
			wptr_q <= '0;
		end else if (cmd.start) begin
			nptr_q <= '0;
			wptr_q <= '0;
		end else begin
			if (cmd.ld_neuron && (nptr_q < NCW'(N_DEPTH)))
				nptr_q <= nptr_q + 1'b1;
			if (cmd.ld_weight && (wptr_q < WCW'(W_DEPTH)))
				wptr_q <= wptr_q + 1'b1;
		end
	end

	// memory writes and registered reads
	always_ff @(posedge clk) begin
		if (cmd.ld_neuron && (nptr_q < NCW'(N_DEPTH)))
			nmem[nptr_q[NAW-1:0]] <= value;
		if (cmd.ld_weight && (wptr_q < WCW'(W_DEPTH)))
			wmem[wptr_q[WAW-1:0]] <= value;
		n_rd_s1 <= nmem[n_addr];
		w_rd_s1 <= wmem[w_addr];
		b_s1    <= cmd.bit_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tap_s1 <= 1'b0;
		else
			tap_s1 <= cmd.tap;
	end

	// weight scaled by the bit weight
	assign addend = {{(SUM_W - VALUE_W){w_rd_s1[VALUE_W-1]}}, w_rd_s1} << b_s1;

	// accumulator, cleared at run start and after each result
	always_ff @(posedge clk) begin
		if (cmd.start || cmd.emit)
			acc_q <= '0;
		else if (tap_s1 && n_rd_s1[b_s1])
			acc_q <= acc_q + addend;
	end

	// output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_data_q <= {1'b0, cmd.out_f, cmd.out_y, cmd.out_x, acc_q};
			out_last_q <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

	// the final tap must be summed before its result is taken
	a_no_emit_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !tap_s1)
		else $error("result emitted with a tap still in flight");

	// a full neuron store ignores further loads
	a_nptr_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ld_neuron && (nptr_q == NCW'(N_DEPTH))) |=> (nptr_q == $past(nptr_q)))
		else $error("neuron pointer moved past full store");

endmodule

// ===== hw/rtl/bit_serial_conv_layer.sv =====
// bit_serial_conv_layer: top level of the bit-serial convolution layer
// depends on bsc_pkg, bsc_ctrl and bsc_datapath
//
//  channel  dir  handshake                     contents
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata: value; tuser: mode
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata: sum, x, y, filter; tlast
//  cfg      in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// a start word runs the outputs in turn, at most MAX_RESULTS of them;
// each output walks neuron_bits * CHANNELS * WIN_Y * WIN_X window taps
// (one window tap per cycle through each memory's single read port), then
// drains and emits; with neuron_bits zero it only emits
// input is taken only while no run is active; the output register lets a
// finished word wait while the next output proceeds up to its emit
// arst_n clears control state; memory contents are unknown until loaded
module bit_serial_conv_layer import bsc_pkg::*; #(
	parameter int IN_X     = 8,
	parameter int IN_Y     = 8,
	parameter int CHANNELS = 3,
	parameter int FILTERS  = 2,
	parameter int WIN_X    = 4,
	parameter int WIN_Y    = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [15:0]           s_axis_tdata,  // [15:0] value
	input  logic [1:0]            s_axis_tuser,  // [1:0] mode
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [39:0] sum, [42:40] out_x,
	                                             // [45:43] out_y, [46] filter_index
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW  = (WIN_X > 1) ? $clog2(WIN_X) : 1;
	localparam int JW  = (WIN_Y > 1) ? $clog2(WIN_Y) : 1;
	localparam int KW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FW  = (FILTERS > 1) ? $clog2(FILTERS) : 1;
	localparam int PXW = $clog2(IN_X + 5);
	localparam int PYW = $clog2(IN_Y + 5);

	bsc_cmd_t       cmd;
	logic [IW-1:0]  tap_i;
	logic [JW-1:0]  tap_j;
	logic [KW-1:0]  tap_k;
	logic [FW-1:0]  tap_f;
	logic [PXW-1:0] corner_x;
	logic [PYW-1:0] corner_y;
	logic           out_free;

	// controller
	bsc_ctrl #(
		.IN_X(IN_X), .IN_Y(IN_Y), .CHANNELS(CHANNELS),
		.FILTERS(FILTERS), .WIN_X(WIN_X), .WIN_Y(WIN_Y)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.out_free (out_free),
		.cmd      (cmd),
		.tap_i    (tap_i),
		.tap_j    (tap_j),
		.tap_k    (tap_k),
		.tap_f    (tap_f),
		.corner_x (corner_x),
		.corner_y (corner_y)
	);

	// datapath
	bsc_datapath #(
		.IN_X(IN_X), .IN_Y(IN_Y), .CHANNELS(CHANNELS),
		.FILTERS(FILTERS), .WIN_X(WIN_X), .WIN_Y(WIN_Y)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.tap_i    (tap_i),
		.tap_j    (tap_j),
		.tap_k    (tap_k),
		.tap_f    (tap_f),
		.corner_x (corner_x),
		.corner_y (corner_y),
		.value    (s_axis_tdata),
		.out_free (out_free),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (m_axis_tdata),
		.out_last (m_axis_tlast)
	);

endmodule
